FILE: sv/salsa_pkg.sv
// Shared types, constants and helper functions for the Salsa20/20 core.
`default_nettype none

package salsa_pkg;

  localparam int WORD_W      = 32;
  localparam int WORDS       = 16;
  localparam int KEY_PART_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int POS_W       = 6;
  localparam int STEP_W      = 2;
  localparam int HALF_ROUNDS = 20;
  localparam int HALF_W      = $clog2(HALF_ROUNDS);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_VALUE = 3'd4;

  // "expand 32-byte k"
  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646E;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2D32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6B20_6574;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WORDS-1:0] block_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              transpose;
  } round_ctrl_t;

  // Build the 16-word input state from constants, key, nonce and counter
  function automatic block_t init_state(input logic [KEY_PART_W-1:0] k0,
                                        input logic [KEY_PART_W-1:0] k1,
                                        input logic [KEY_PART_W-1:0] k2,
                                        input logic [KEY_PART_W-1:0] k3,
                                        input logic [KEY_PART_W-1:0] nonce,
                                        input logic [KEY_PART_W-1:0] counter);
    block_t b;
    b[0]  = SIGMA0;
    b[1]  = k0[31:0];
    b[2]  = k0[63:32];
    b[3]  = k1[31:0];
    b[4]  = k1[63:32];
    b[5]  = SIGMA1;
    b[6]  = nonce[31:0];
    b[7]  = nonce[63:32];
    b[8]  = counter[31:0];
    b[9]  = counter[63:32];
    b[10] = SIGMA2;
    b[11] = k2[31:0];
    b[12] = k2[63:32];
    b[13] = k3[31:0];
    b[14] = k3[63:32];
    b[15] = SIGMA3;
    return b;
  endfunction

  // Rotate left by 7, 9, 13 or 18 for quarter-round steps one to four
  function automatic word_t rotl_step(input word_t v, input logic [STEP_W-1:0] step_idx);
    word_t r;
    case (step_idx)
      2'd0:    r = {v[24:0], v[31:25]};
      2'd1:    r = {v[22:0], v[31:23]};
      2'd2:    r = {v[18:0], v[31:19]};
      2'd3:    r = {v[13:0], v[31:14]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/salsa_round.sv
// Round unit: four quarter-round lanes, one add-rotate-xor step per cycle while ctrl.step is set.
`default_nettype none

module salsa_round (
  input  wire                      clk,
  input  salsa_pkg::round_ctrl_t   ctrl,
  input  salsa_pkg::block_t        init_words,
  output salsa_pkg::block_t        words
);
  import salsa_pkg::*;

  // slot[p][c]: column c, physical row p. During step s it holds logical
  // row (p + s) mod 4, so every lane reads and writes fixed slots.
  word_t slot     [4][4];
  word_t stepped  [4][4];
  word_t lane_sum [4];
  word_t lane_mix [4];

  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam int JP = (j + 1) % 4;
    localparam int JM = (j + 3) % 4;
    assign lane_sum[j] = slot[j][j] + slot[JM][j];
    assign lane_mix[j] = slot[JP][j] ^ rotl_step(lane_sum[j], ctrl.step_idx);
  end

  // Rotate each column up by one row, dropping in the freshly mixed word
  for (genvar p = 0; p < 4; p++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      localparam int PN = (p + 1) % 4;
      if (p == c) begin : g_mix
        assign stepped[p][c] = lane_mix[c];
      end else begin : g_shift
        assign stepped[p][c] = slot[PN][c];
      end
      assign words[p*4 + c] = slot[p][c];
    end
  end

  // The row round is the column round on the transposed matrix: transpose
  // at the end of every half round.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (ctrl.load) begin
          slot[r][c] <= init_words[r*4 + c];
        end else if (ctrl.step) begin
          if (ctrl.transpose) begin
            slot[r][c] <= stepped[c][r];
          end else begin
            slot[r][c] <= stepped[r][c];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/salsa20_stream_cipher_core.sv
// Top level of the Salsa20/20 byte stream cipher core.
//
//   channel  signals                              width   direction
//   input    in_valid, in_ready, data_byte,       8 + 1   into core
//            is_last
//   output   out_valid, out_ready, out_byte,      8 + 1   out of core
//            out_last
//   config   cfg_we, cfg_index, cfg_data          3 / 64  into core
//
// A byte at block position zero starts a keystream block: the shared round
// unit runs 20 half rounds of four add-rotate-xor steps (S_ROUND), then
// S_FINAL adds the feed-forward and registers its result. Other bytes give
// their result in the cycle after acceptance. Reset is synchronous and
// clears keys, nonce, counter and position. The core takes no byte while a
// result waits.
`default_nettype none

module salsa20_stream_cipher_core (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [7:0]                           data_byte,
  input  wire                                  is_last,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 out_last,
  input  wire                                  cfg_we,
  input  wire  [salsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [salsa_pkg::KEY_PART_W-1:0]     cfg_data
);
  import salsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  localparam logic [HALF_W-1:0] LAST_HALF = HALF_W'(HALF_ROUNDS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = '1;

  state_t                  state;
  logic [KEY_PART_W-1:0]   key_part0, key_part1, key_part2, key_part3;
  logic [KEY_PART_W-1:0]   nonce_value;
  logic [KEY_PART_W-1:0]   block_counter;
  logic [POS_W-1:0]        byte_position;
  word_t                   keystream_words [WORDS];
  logic [STEP_W-1:0]       step_idx;
  logic [HALF_W-1:0]       half_idx;
  logic [7:0]              data_hold;
  logic                    last_hold;

  block_t                  init_words;
  block_t                  round_out;
  word_t                   ks_sum [WORDS];
  round_ctrl_t             round_ctrl;
  logic                    accept;
  logic                    cfg_hit;
  word_t                   ks_word;
  logic [7:0]              ks_byte;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_we && (cfg_index <= REG_NONCE_VALUE);

  assign init_words = init_state(key_part0, key_part1, key_part2, key_part3,
                                 nonce_value, block_counter);

  assign round_ctrl.load      = accept && (byte_position == '0);
  assign round_ctrl.step      = (state == S_ROUND);
  assign round_ctrl.step_idx  = step_idx;
  assign round_ctrl.transpose = (step_idx == LAST_STEP);

  salsa_round u_round (
    .clk        (clk),
    .ctrl       (round_ctrl),
    .init_words (init_words),
    .words      (round_out)
  );

  always_comb begin
    for (int i = 0; i < WORDS; i++) begin
      ks_sum[i] = round_out[i] + init_words[i];
    end
  end

  assign ks_word = keystream_words[byte_position[POS_W-1:2]];
  assign ks_byte = ks_word[{byte_position[1:0], 3'b000} +: 8];

  // Finished keystream block; no reset needed
  always_ff @(posedge clk) begin
    if (state == S_FINAL) begin
      for (int i = 0; i < WORDS; i++) begin
        keystream_words[i] <= ks_sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      key_part0     <= '0;
      key_part1     <= '0;
      key_part2     <= '0;
      key_part3     <= '0;
      nonce_value   <= '0;
      block_counter <= '0;
      byte_position <= '0;
      step_idx      <= '0;
      half_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            data_hold <= data_byte;
            last_hold <= is_last;
            if (byte_position == '0) begin
              step_idx <= '0;
              half_idx <= '0;
              state    <= S_ROUND;
            end else begin
              out_byte      <= data_byte ^ ks_byte;
              out_last      <= is_last;
              out_valid     <= 1'b1;
              byte_position <= is_last ? '0 : byte_position + POS_W'(1);
            end
          end
        end
        S_ROUND: begin
          step_idx <= step_idx + STEP_W'(1);
          if (step_idx == LAST_STEP) begin
            half_idx <= half_idx + HALF_W'(1);
            if (half_idx == LAST_HALF) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          block_counter <= block_counter + KEY_PART_W'(1);
          out_byte      <= data_hold ^ ks_sum[0][7:0];
          out_last      <= last_hold;
          out_valid     <= 1'b1;
          byte_position <= last_hold ? '0 : POS_W'(1);
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Key or nonce write: restart the stream under the new setting
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_PART0:   key_part0   <= cfg_data;
          REG_KEY_PART1:   key_part1   <= cfg_data;
          REG_KEY_PART2:   key_part2   <= cfg_data;
          REG_KEY_PART3:   key_part3   <= cfg_data;
          REG_NONCE_VALUE: nonce_value <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        block_counter <= '0;
        byte_position <= '0;
      end
    end
  end

endmodule

`default_nettype wire
